@@ design/button_press_classifier_core_assert.svh @@
// assertion macros for the button press classifier checker
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// next-cycle implication, disabled during reset
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

@@ design/bpc_pkg.sv @@
// shared types and constants of the button press classifier
package bpc_pkg;

  localparam int unsigned SINGLE_SLOTS = 2;
  localparam int unsigned WIN_W        = 16;
  localparam int unsigned DBT_W        = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [DBT_W-1:0] STABLE_MAX = {DBT_W{1'b1}};
  localparam logic [WIN_W-1:0] WIN_MAX    = {WIN_W{1'b1}};

  localparam logic [DBT_W-1:0] DBT_RESET  = DBT_W'(20);
  localparam logic [WIN_W-1:0] DWIN_RESET = WIN_W'(500);
  localparam logic [WIN_W-1:0] LWIN_RESET = WIN_W'(3000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOUBLE   = 2'd1,
    REG_LONG     = 2'd2
  } cfg_reg_e;

endpackage

@@ design/bpc_if.sv @@
// handshake channels of the button press classifier
interface bpc_in_if;
  logic valid;
  logic ready;
  logic raw_pin;

  modport source (output valid, output raw_pin, input ready);
  modport sink   (input valid, input raw_pin, output ready);
endinterface

interface bpc_out_if;
  logic valid;
  logic ready;
  logic button_level;
  logic press_event;
  logic release_event;
  logic single_press;
  logic double_press;
  logic long_press;

  modport source (output valid, output button_level, output press_event,
                  output release_event, output single_press, output double_press,
                  output long_press, input ready);
  modport sink   (input valid, input button_level, input press_event,
                  input release_event, input single_press, input double_press,
                  input long_press, output ready);
endinterface

interface bpc_cfg_if
  import bpc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/button_press_classifier_core.sv @@
// button debounce with single, double and long press classification
// each result word is registered and shown in the cycle after its word is accepted
// throughput: one word per cycle; ready drops only while a result is stalled
// every counter update for a word fits in one pass of logic before the result register
// reset: asynchronous, active low; clears all timers and state, loads default debounce time and windows;
// result data registers are not reset; configuration writes are taken in any cycle, ready is always high
module button_press_classifier_core
  import bpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bpc_in_if.sink     in_i,
  bpc_cfg_if.sink    cfg_i,
  bpc_out_if.source  out_o
);

  logic [DBT_W-1:0] dbt_q;
  logic [WIN_W-1:0] dwin_q, lwin_q;

  logic             last_raw_q, last_raw_d;
  logic [DBT_W-1:0] stable_q, stable_d;
  logic             level_q, level_d;
  logic [WIN_W-1:0] age_q, age_d;
  logic             seen_q, seen_d;
  logic             armed_q, armed_d;
  logic             fired_q, fired_d;
  logic [WIN_W-1:0] block_q, block_d;
  logic             busy_q [SINGLE_SLOTS];
  logic             busy_d [SINGLE_SLOTS];
  logic [WIN_W-1:0] left_q [SINGLE_SLOTS];
  logic [WIN_W-1:0] left_d [SINGLE_SLOTS];

  logic press, release_ev, single, dbl, lng, taken;

  logic out_valid_q;
  logic level_out_q, press_q, release_q, single_q, dbl_q, lng_q;
  logic accept;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    block_d    = block_q;
    last_raw_d = last_raw_q;
    stable_d   = stable_q;
    level_d    = level_q;
    age_d      = age_q;
    seen_d     = seen_q;
    armed_d    = armed_q;
    fired_d    = fired_q;
    press      = 1'b0;
    release_ev = 1'b0;
    single     = 1'b0;
    dbl        = 1'b0;
    lng        = 1'b0;
    taken      = 1'b0;

    if (block_q != '0) begin
      block_d = block_q - 1'b1;
    end

    for (int i = 0; i < SINGLE_SLOTS; i++) begin
      busy_d[i] = busy_q[i];
      left_d[i] = left_q[i];
      if (busy_q[i]) begin
        if (left_q[i] <= WIN_W'(1)) begin
          busy_d[i] = 1'b0;
          left_d[i] = '0;
          if (block_d == '0) begin
            single = 1'b1;
          end
        end else begin
          left_d[i] = left_q[i] - 1'b1;
        end
      end
    end

    if (seen_q && age_q != WIN_MAX) begin
      age_d = age_q + 1'b1;
    end

    // debouncer
    if (in_i.raw_pin != last_raw_q) begin
      last_raw_d = in_i.raw_pin;
      stable_d   = '0;
    end else if (stable_q != STABLE_MAX) begin
      stable_d = stable_q + 1'b1;
    end
    if (stable_d >= dbt_q && in_i.raw_pin != level_q) begin
      level_d    = in_i.raw_pin;
      press      = in_i.raw_pin;
      release_ev = !in_i.raw_pin;
    end

    if (press) begin
      if (seen_q && age_d < dwin_q) begin
        dbl     = 1'b1;
        block_d = dwin_q;
      end
      age_d   = '0;
      seen_d  = 1'b1;
      armed_d = 1'b1;
    end

    if (release_ev) begin
      armed_d = 1'b0;
      if (block_d == '0 && !fired_q) begin
        // first idle slot takes the single-press wait
        for (int i = 0; i < SINGLE_SLOTS; i++) begin
          if (!busy_d[i] && !taken) begin
            busy_d[i] = 1'b1;
            left_d[i] = dwin_q;
            taken     = 1'b1;
          end
        end
      end
      fired_d = 1'b0;
    end

    if (armed_d && age_d >= lwin_q) begin
      lng     = 1'b1;
      armed_d = 1'b0;
      fired_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbt_q  <= DBT_RESET;
      dwin_q <= DWIN_RESET;
      lwin_q <= LWIN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_DEBOUNCE: dbt_q  <= cfg_i.data[DBT_W-1:0];
        REG_DOUBLE:   dwin_q <= cfg_i.data[WIN_W-1:0];
        REG_LONG:     lwin_q <= cfg_i.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= '0;
      level_q    <= 1'b0;
      age_q      <= '0;
      seen_q     <= 1'b0;
      armed_q    <= 1'b0;
      fired_q    <= 1'b0;
      block_q    <= '0;
      for (int i = 0; i < SINGLE_SLOTS; i++) begin
        busy_q[i] <= 1'b0;
        left_q[i] <= '0;
      end
    end else if (accept) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      level_q    <= level_d;
      age_q      <= age_d;
      seen_q     <= seen_d;
      armed_q    <= armed_d;
      fired_q    <= fired_d;
      block_q    <= block_d;
      for (int i = 0; i < SINGLE_SLOTS; i++) begin
        busy_q[i] <= busy_d[i];
        left_q[i] <= left_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_out_q <= level_d;
      press_q     <= press;
      release_q   <= release_ev;
      single_q    <= single;
      dbl_q       <= dbl;
      lng_q       <= lng;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.button_level  = level_out_q;
  assign out_o.press_event   = press_q;
  assign out_o.release_event = release_q;
  assign out_o.single_press  = single_q;
  assign out_o.double_press  = dbl_q;
  assign out_o.long_press    = lng_q;

endmodule

@@ design/bpc_checker.sv @@
// port-level checker for the button press classifier, with its bind
`include "button_press_classifier_core_assert.svh"

module bpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic button_level_i,
  input logic press_event_i,
  input logic release_event_i,
  input logic double_press_i
);

  `BPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `BPC_ASSERT_NEXT(a_word_lands, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i)
  `BPC_ASSERT_IMPLY(a_press_level, clk_i, rst_ni, out_valid_i && press_event_i, button_level_i && !release_event_i)
  `BPC_ASSERT_IMPLY(a_release_level, clk_i, rst_ni, out_valid_i && release_event_i, !button_level_i)
  `BPC_ASSERT_IMPLY(a_double_on_press, clk_i, rst_ni, out_valid_i && double_press_i, press_event_i)

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .button_level_i  (out_o.button_level),
  .press_event_i   (out_o.press_event),
  .release_event_i (out_o.release_event),
  .double_press_i  (out_o.double_press)
);
